// ----- sv/bb3_pkg.sv -----
`timescale 1ns / 1ps

package bb3_pkg;

    localparam int CFG_W  = 11;
    localparam int ROW_W  = 11;
    localparam int CH_W   = 8;
    localparam int SUM_W  = 12;
    localparam int RECIP_W = 13;
    localparam int MEAN_SHIFT = 16;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;
    localparam logic [CFG_W-1:0] HEIGHT_LIMIT = 11'd1024;
    localparam logic [CFG_W-1:0] MIN_DIM      = 11'd3;

    // floor(s / 9) == (s * 7282) >> 16 for every s up to 9 * 255
    localparam logic [RECIP_W-1:0] RECIP_NINE = 13'd7282;

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic have;      // item yields an output pixel
        logic use_last;  // center comes from the last column of the upper line
        logic border;    // pass through, no averaging
        logic eol;
        logic eof;
    } bb3_ctl_t;

endpackage

// ----- sv/bb3_line_store.sv -----
`timescale 1ns / 1ps

module bb3_line_store
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    input  logic [$clog2(MAX_WIDTH)-1:0] last_addr,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
    input  pixel_t                       wr_upper,
    input  pixel_t                       wr_middle,
    output pixel_t                       up,
    output pixel_t                       mid,
    output pixel_t                       last
);

    pixel_t upper_mem  [MAX_WIDTH];
    pixel_t middle_mem [MAX_WIDTH];

    pixel_t up_raw_reg;
    pixel_t mid_raw_reg;
    pixel_t last_raw_reg;
    pixel_t fwd_upper_reg;
    pixel_t fwd_middle_reg;
    logic   hit_reg;
    logic   last_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            upper_mem[wr_addr]  <= wr_upper;
            middle_mem[wr_addr] <= wr_middle;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            up_raw_reg     <= upper_mem[rd_addr];
            mid_raw_reg    <= middle_mem[rd_addr];
            last_raw_reg   <= upper_mem[last_addr];
            fwd_upper_reg  <= wr_upper;
            fwd_middle_reg <= wr_middle;
        end
    end

    // a write in the same cycle as the read is missed by the array, take it from the bypass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg      <= 1'b0;
            last_hit_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            hit_reg      <= wr_en && (wr_addr == rd_addr);
            last_hit_reg <= wr_en && (wr_addr == last_addr);
        end
    end

    assign up   = hit_reg      ? fwd_upper_reg  : up_raw_reg;
    assign mid  = hit_reg      ? fwd_middle_reg : mid_raw_reg;
    assign last = last_hit_reg ? fwd_upper_reg  : last_raw_reg;

endmodule

// ----- sv/bb3_filter.sv -----
`timescale 1ns / 1ps

module bb3_filter
    import bb3_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       shift_en,
    input  pixel_t     up,
    input  pixel_t     mid,
    input  pixel_t     px,
    input  pixel_t     last,
    input  bb3_ctl_t   ctl,
    output logic       filt_ready,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [23:0] m_tdata,   // out_red, out_green, out_blue
    output logic       m_tlast,    // end_of_line
    output logic       m_tuser     // end_of_frame
);

    localparam int PROD_W = SUM_W + RECIP_W;

    pixel_t   window_reg [9];

    logic     v2_reg;
    logic     v2_next;
    pixel_t   center2_reg;
    bb3_ctl_t ctl2_reg;

    logic     v3_reg;
    logic     v3_next;
    pixel_t   center3_reg;
    bb3_ctl_t ctl3_reg;
    logic [SUM_W-1:0] sum_red_reg;
    logic [SUM_W-1:0] sum_green_reg;
    logic [SUM_W-1:0] sum_blue_reg;

    logic     out_valid_reg;
    logic     out_valid_next;
    pixel_t   out_pix_reg;
    logic     out_eol_reg;
    logic     out_eof_reg;

    logic     mv2;
    logic     mv3;
    logic [SUM_W-1:0]  sum_red;
    logic [SUM_W-1:0]  sum_green;
    logic [SUM_W-1:0]  sum_blue;
    logic [PROD_W-1:0] prod_red;
    logic [PROD_W-1:0] prod_green;
    logic [PROD_W-1:0] prod_blue;
    pixel_t            mean_pix;

    assign mv3        = v3_reg && (!out_valid_reg || m_tready);
    assign mv2        = v2_reg && (!v3_reg || mv3);
    assign filt_ready = !v2_reg || mv2;

    // 3x3 window, right column takes the two line store outputs and the new pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 9; k++)
            begin
                window_reg[k] <= '0;
            end
        end
        else if (shift_en)
        begin
            window_reg[0] <= window_reg[1];
            window_reg[1] <= window_reg[2];
            window_reg[2] <= up;
            window_reg[3] <= window_reg[4];
            window_reg[4] <= window_reg[5];
            window_reg[5] <= mid;
            window_reg[6] <= window_reg[7];
            window_reg[7] <= window_reg[8];
            window_reg[8] <= px;
        end
    end

    always_comb
    begin
        v2_next = v2_reg;
        if (shift_en)
        begin
            v2_next = ctl.have;
        end
        else if (mv2)
        begin
            v2_next = 1'b0;
        end
    end

    always_comb
    begin
        v3_next = v3_reg;
        if (mv2)
        begin
            v3_next = 1'b1;
        end
        else if (mv3)
        begin
            v3_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (mv3)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v2_reg        <= v2_next;
            v3_reg        <= v3_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // window_reg[5] before the shift is the center after it
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            center2_reg <= ctl.use_last ? last : window_reg[5];
            ctl2_reg    <= ctl;
        end
    end

    always_comb
    begin
        sum_red   = '0;
        sum_green = '0;
        sum_blue  = '0;
        for (int k = 0; k < 9; k++)
        begin
            sum_red   = sum_red   + SUM_W'(window_reg[k].red);
            sum_green = sum_green + SUM_W'(window_reg[k].green);
            sum_blue  = sum_blue  + SUM_W'(window_reg[k].blue);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mv2)
        begin
            sum_red_reg   <= sum_red;
            sum_green_reg <= sum_green;
            sum_blue_reg  <= sum_blue;
            center3_reg   <= center2_reg;
            ctl3_reg      <= ctl2_reg;
        end
    end

    assign prod_red   = PROD_W'(sum_red_reg)   * PROD_W'(RECIP_NINE);
    assign prod_green = PROD_W'(sum_green_reg) * PROD_W'(RECIP_NINE);
    assign prod_blue  = PROD_W'(sum_blue_reg)  * PROD_W'(RECIP_NINE);

    always_comb
    begin
        mean_pix.red   = prod_red[MEAN_SHIFT +: CH_W];
        mean_pix.green = prod_green[MEAN_SHIFT +: CH_W];
        mean_pix.blue  = prod_blue[MEAN_SHIFT +: CH_W];
    end

    always_ff @(posedge clk)
    begin
        if (mv3)
        begin
            out_pix_reg <= ctl3_reg.border ? center3_reg : mean_pix;
            out_eol_reg <= ctl3_reg.eol;
            out_eof_reg <= ctl3_reg.eof;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_pix_reg.blue, out_pix_reg.green, out_pix_reg.red};
    assign m_tlast  = out_eol_reg;
    assign m_tuser  = out_eof_reg;

endmodule

// ----- sv/box_blur_3x3_rgb.sv -----
`timescale 1ns / 1ps

// 3x3 box filter (truncated mean per channel) on an RGB raster stream.
// Input beats on s_*: tdata = red, green, blue from bit 0 up; tuser = flush.
// Output beats on m_*: tdata = filtered red, green, blue; tlast = end of line;
// tuser = end of frame. cfg_we/cfg_addr/cfg_wdata set image width (index 0)
// and height (index 1), clamped to 3..MAX_WIDTH and 3..1024.
// One beat per clock in and out while m_tready stays high. The output
// for pixel (r, c) leaves once pixel (r+1, c+1) has been taken, or pixel
// (r+2, 0) for the last column, then passes the line store read, window,
// adder and multiplier stages. After the last pixel of a frame send width+1
// flush beats to drain the last line; a flush beat inside a frame is dropped.
// Rows and columns on the frame edge pass through unchanged.
// Rate is set by the line stores: one read and one write per beat, with a
// bypass when the write lands on the address being read.
// Reset clears the position counters, window and pipeline and loads 640x480;
// the line stores are not cleared; unwritten entries feed only discarded sums.
// When m_tready is low the output beat holds, the pipeline fills and then
// s_tready drops.

module box_blur_3x3_rgb
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [23:0]      s_tdata,    // in_red, in_green, in_blue
    input  logic             s_tuser,    // is_flush
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [23:0]      m_tdata,    // out_red, out_green, out_blue
    output logic             m_tlast,    // end_of_line
    output logic             m_tuser,    // end_of_frame
    input  logic             cfg_we,
    input  logic             cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WU_W  = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;

    logic [CFG_W-1:0] width_cfg_reg;
    logic [CFG_W-1:0] height_cfg_reg;
    logic [WU_W-1:0]  w_used;
    logic [ROW_W-1:0] h_used;

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;

    logic             v1_reg;
    logic             v1_next;
    pixel_t           px1_reg;
    logic [COL_W-1:0] ci1_reg;
    bb3_ctl_t         ctl1_reg;

    logic             accept;
    logic             drain;
    logic             take;
    logic             col_nz;
    logic [ROW_W-1:0] qr;
    logic [WU_W-1:0]  qc;
    logic [WU_W-1:0]  w_m1;
    logic             line_end;
    bb3_ctl_t         ctl_c;
    pixel_t           px_c;

    logic             mv1;
    logic             filt_ready;
    pixel_t           up_q;
    pixel_t           mid_q;
    pixel_t           last_q;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= WIDTH_RESET;
            height_cfg_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_addr))
                REG_IMAGE_WIDTH:  width_cfg_reg  <= cfg_wdata;
                REG_IMAGE_HEIGHT: height_cfg_reg <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        w_used = WU_W'(width_cfg_reg);
        if (width_cfg_reg < MIN_DIM)
        begin
            w_used = WU_W'(MIN_DIM);
        end
        else if (WU_W'(width_cfg_reg) > WU_W'(MAX_WIDTH))
        begin
            w_used = WU_W'(MAX_WIDTH);
        end
        h_used = height_cfg_reg;
        if (height_cfg_reg < MIN_DIM)
        begin
            h_used = MIN_DIM;
        end
        else if (height_cfg_reg > HEIGHT_LIMIT)
        begin
            h_used = HEIGHT_LIMIT;
        end
    end

    // position tracking and per-pixel decisions
    assign s_tready = !v1_reg || mv1;
    assign accept   = s_tvalid && s_tready;
    assign drain    = row_reg >= h_used;
    assign take     = accept && (drain || !s_tuser);
    assign col_nz   = col_reg != '0;
    assign w_m1     = w_used - WU_W'(1);

    always_comb
    begin
        px_c.red   = s_tdata[7:0];
        px_c.green = s_tdata[15:8];
        px_c.blue  = s_tdata[23:16];
        if (drain)
        begin
            px_c = '0;
        end
    end

    always_comb
    begin
        qr             = col_nz ? row_reg - ROW_W'(1) : row_reg - ROW_W'(2);
        qc             = col_nz ? WU_W'(col_reg) - WU_W'(1) : w_m1;
        ctl_c.have     = col_nz ? (row_reg >= ROW_W'(1)) : (row_reg >= ROW_W'(2));
        ctl_c.use_last = !col_nz;
        ctl_c.eol      = qc >= w_m1;
        ctl_c.border   = (qr == '0) || (qr >= h_used - ROW_W'(1))
                         || (qc == '0) || ctl_c.eol;
        ctl_c.eof      = !col_nz
                         && ((ROW_W + 1)'(row_reg) >= (ROW_W + 1)'(h_used) + (ROW_W + 1)'(1));
    end

    assign line_end = (WU_W'(col_reg) + WU_W'(1)) >= w_used;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (take)
        begin
            if (ctl_c.have && ctl_c.eof)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (line_end)
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_comb
    begin
        v1_next = v1_reg;
        if (take)
        begin
            v1_next = 1'b1;
        end
        else if (mv1)
        begin
            v1_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            v1_reg  <= 1'b0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            v1_reg  <= v1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            px1_reg  <= px_c;
            ci1_reg  <= col_reg;
            ctl1_reg <= ctl_c;
        end
    end

    assign mv1 = v1_reg && filt_ready;

    bb3_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (take),
        .rd_addr   (col_reg),
        .last_addr (COL_W'(w_m1)),
        .wr_en     (mv1),
        .wr_addr   (ci1_reg),
        .wr_upper  (mid_q),
        .wr_middle (px1_reg),
        .up        (up_q),
        .mid       (mid_q),
        .last      (last_q)
    );

    bb3_filter u_filter (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift_en   (mv1),
        .up         (up_q),
        .mid        (mid_q),
        .px         (px1_reg),
        .last       (last_q),
        .ctl        (ctl1_reg),
        .filt_ready (filt_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    // end of frame always falls on the last column
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("end of frame without end of line");

    // a flush beat inside a frame must not move the position
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && !take |=> $stable(col_reg) && $stable(row_reg))
        else $error("stray flush changed position");

    // the frame-closing beat restarts at the origin
    assert property (@(posedge clk) disable iff (!rst_n)
        take && ctl_c.eof |=> (col_reg == '0) && (row_reg == '0))
        else $error("frame did not restart after end of frame");

    // a beat cannot enter while the line store stage holds a stalled beat
    assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && !filt_ready |-> !accept)
        else $error("beat accepted over a stalled line store stage");

endmodule
